FILE: rtl/core/lay_pkg.sv
// Shared types and constants for the look-at yaw/pitch core.
// Holds the channel payload structs, queue status and the CORDIC arctangent table.
// Depends on nothing; every other file in rtl/core imports it.
package lay_pkg;

   localparam int COORD_W     = 32;
   localparam int DIFF_W      = 33;
   localparam int NORM_W      = 31;
   localparam int PITCH_W     = 15;
   localparam int YAW_W       = 16;
   localparam int ACC_FRAC    = 16;
   localparam int Z_W         = 27;
   localparam int CX_W        = 34;
   localparam int SQ_W        = 62;
   localparam int ROOT_STEPS  = 31;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;

   typedef struct packed {
      logic signed [COORD_W-1:0] eye_x;
      logic signed [COORD_W-1:0] eye_y;
      logic signed [COORD_W-1:0] eye_z;
      logic signed [COORD_W-1:0] target_x;
      logic signed [COORD_W-1:0] target_y;
      logic signed [COORD_W-1:0] target_z;
   } lay_req_type;

   typedef struct packed {
      logic signed [PITCH_W-1:0] pitch_angle;
      logic signed [YAW_W-1:0]   yaw_angle;
      logic                      degenerate;
   } lay_rsp_type;

   typedef struct packed {
      logic signed [NORM_W-1:0] nx;
      logic signed [NORM_W-1:0] ny;
      logic signed [NORM_W-1:0] nz;
      logic                     degenerate;
   } lay_vec_type;

   typedef struct packed {
      logic not_empty;
      logic full;
   } lay_qstat_type;

   // atan(2^-i) in degrees, scaled by 2^16 and rounded to nearest.
   function automatic logic signed [Z_W-1:0] atan_deg(input logic [4:0] i);
      logic signed [Z_W-1:0] v;
      case (i)
         5'd0:    v = Z_W'(2949120);
         5'd1:    v = Z_W'(1740967);
         5'd2:    v = Z_W'(919879);
         5'd3:    v = Z_W'(466945);
         5'd4:    v = Z_W'(234379);
         5'd5:    v = Z_W'(117304);
         5'd6:    v = Z_W'(58666);
         5'd7:    v = Z_W'(29335);
         5'd8:    v = Z_W'(14668);
         5'd9:    v = Z_W'(7334);
         5'd10:   v = Z_W'(3667);
         5'd11:   v = Z_W'(1833);
         5'd12:   v = Z_W'(917);
         5'd13:   v = Z_W'(458);
         5'd14:   v = Z_W'(229);
         5'd15:   v = Z_W'(115);
         5'd16:   v = Z_W'(57);
         5'd17:   v = Z_W'(29);
         5'd18:   v = Z_W'(14);
         5'd19:   v = Z_W'(7);
         5'd20:   v = Z_W'(4);
         5'd21:   v = Z_W'(2);
         5'd22:   v = Z_W'(1);
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

FILE: rtl/core/look_at_yaw_pitch_core.sv
// Top level of the look-at yaw/pitch core: front end, queue and angle pipeline.
// Depends on lay_pkg, lay_front, lay_queue and lay_back.
//
// Usage:
//   A request transaction carries an eye point and a target point in signed
//   Q16.16. Each one yields exactly one response transaction with pitch, yaw
//   (plus a half turn, wrapped) in 2^-ANGLE_FRAC_BITS degree units and a flag
//   that is set when eye and target coincide.
//   Throughput is one transaction per cycle while no stall holds the flow.
//   A transaction passes six front stages, the queue, the 31 square-root
//   steps that also carry the yaw CORDIC, the pitch CORDIC and the output
//   register. When the receiver raises rsp_stall while a result is offered,
//   the angle pipeline freezes and the result is held; the front end keeps
//   taking requests until the four-entry queue is full and a vector waits in
//   the last front stage, after which req_stall is raised.
//   Reset empties the pipelines and the queue; nothing else needs clearing.
module look_at_yaw_pitch_core #(
   parameter int CORDIC_STEPS    = 16,
   parameter int ANGLE_FRAC_BITS = 7
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  lay_pkg::lay_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output lay_pkg::lay_rsp_type rsp_data
);
   import lay_pkg::*;

   logic          q_push, q_pop, q_room;
   lay_vec_type   q_in, q_head;
   lay_qstat_type q_stat;

   assign q_room = !q_stat.full || q_pop;

   lay_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_room    (q_room),
      .q_push    (q_push),
      .q_data    (q_in)
   );

   lay_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .pop       (q_pop),
      .head      (q_head),
      .stat      (q_stat)
   );

   lay_back #(
      .CORDIC_STEPS    (CORDIC_STEPS),
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_head    (q_head),
      .q_stat    (q_stat),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // The queue is never written when full unless an entry leaves in the same cycle.
   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      q_push && q_stat.full |-> q_pop)
      else $error("queue written while full");

   a_no_underflow : assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_stat.not_empty)
      else $error("queue read while empty");

   a_degenerate_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.degenerate |->
         rsp_data.pitch_angle == '0 && rsp_data.yaw_angle == '0)
      else $error("degenerate result carries non-zero angles");

   // A held result must still be offered in the next cycle.
   a_hold_result : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

endmodule

FILE: rtl/core/lay_front.sv
// Front end: forms the direction vector, flags the degenerate case and normalises it.
// Six registered stages feeding the queue; depends on lay_pkg.
module lay_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  lay_pkg::lay_req_type req_data,
   input  logic                 q_room,
   output logic                 q_push,
   output lay_pkg::lay_vec_type q_data
);
   import lay_pkg::*;

   typedef struct packed {
      logic [DIFF_W-1:0] mx;
      logic [DIFF_W-1:0] my;
      logic [DIFF_W-1:0] mz;
      logic              sx;
      logic              sy;
      logic              sz;
      logic              degenerate;
   } mag_type;

   logic en;

   logic                     f1_valid_ff;
   logic signed [DIFF_W-1:0] f1_dx_ff, f1_dy_ff, f1_dz_ff;
   logic                     f2_valid_ff, f3_valid_ff, f4_valid_ff, f5_valid_ff, f6_valid_ff;
   mag_type                  f2_ff, f3_ff, f4_ff, f5_ff;
   mag_type                  f2_in;
   logic [DIFF_W-1:0]        f3_max_ff, f3_max_in;
   logic [2:0]               f4_chunk_ff, f4_chunk_in;
   logic [7:0]               f4_byte_ff, f4_byte_in;
   logic [4:0]               f5_left_ff, f5_left_in;
   logic [1:0]               f5_right_ff, f5_right_in;
   lay_vec_type              f6_ff, f6_in;

   assign en        = !f6_valid_ff || q_room;
   assign req_stall = !en;
   assign q_push    = f6_valid_ff && q_room;
   assign q_data    = f6_ff;

   always_comb begin
      f2_in.sx = f1_dx_ff[DIFF_W-1];
      f2_in.sy = f1_dy_ff[DIFF_W-1];
      f2_in.sz = f1_dz_ff[DIFF_W-1];
      f2_in.mx = f2_in.sx ? DIFF_W'(-f1_dx_ff) : DIFF_W'(f1_dx_ff);
      f2_in.my = f2_in.sy ? DIFF_W'(-f1_dy_ff) : DIFF_W'(f1_dy_ff);
      f2_in.mz = f2_in.sz ? DIFF_W'(-f1_dz_ff) : DIFF_W'(f1_dz_ff);
      f2_in.degenerate = (f1_dx_ff == '0) && (f1_dy_ff == '0) && (f1_dz_ff == '0);
   end

   always_comb begin
      f3_max_in = f2_ff.mx;
      if (f2_ff.my > f3_max_in) f3_max_in = f2_ff.my;
      if (f2_ff.mz > f3_max_in) f3_max_in = f2_ff.mz;
   end

   // Coarse search: pick the highest non-zero byte of the largest magnitude.
   always_comb begin
      logic [39:0] ext;
      ext         = {7'b0, f3_max_ff};
      f4_chunk_in = '0;
      for (int c = 0; c < 5; c++) begin
         if (ext[8*c +: 8] != 8'b0) f4_chunk_in = 3'(c);
      end
      f4_byte_in = ext[8*f4_chunk_in +: 8];
   end

   // Fine search within the byte, then the shift that puts the top bit at 29.
   always_comb begin
      logic [2:0] pos;
      logic [5:0] p;
      pos = '0;
      for (int i = 0; i < 8; i++) begin
         if (f4_byte_ff[i]) pos = 3'(i);
      end
      p           = {f4_chunk_ff, 3'b000} + 6'(pos);
      f5_left_in  = (p < 6'd29) ? 5'(6'd29 - p) : 5'd0;
      f5_right_in = (p > 6'd29) ? 2'(p - 6'd29) : 2'd0;
   end

   always_comb begin
      logic [63:0]              tx, ty, tz;
      logic signed [NORM_W-1:0] vx, vy, vz;
      tx = (64'(f5_ff.mx) << f5_left_ff) >> f5_right_ff;
      ty = (64'(f5_ff.my) << f5_left_ff) >> f5_right_ff;
      tz = (64'(f5_ff.mz) << f5_left_ff) >> f5_right_ff;
      vx = {1'b0, tx[NORM_W-2:0]};
      vy = {1'b0, ty[NORM_W-2:0]};
      vz = {1'b0, tz[NORM_W-2:0]};
      f6_in.nx = f5_ff.sx ? -vx : vx;
      f6_in.ny = f5_ff.sy ? -vy : vy;
      f6_in.nz = f5_ff.sz ? -vz : vz;
      f6_in.degenerate = f5_ff.degenerate;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
         f3_valid_ff <= 1'b0;
         f4_valid_ff <= 1'b0;
         f5_valid_ff <= 1'b0;
         f6_valid_ff <= 1'b0;
      end else if (en) begin
         f1_valid_ff <= req_valid;
         f2_valid_ff <= f1_valid_ff;
         f3_valid_ff <= f2_valid_ff;
         f4_valid_ff <= f3_valid_ff;
         f5_valid_ff <= f4_valid_ff;
         f6_valid_ff <= f5_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f1_dx_ff    <= DIFF_W'(req_data.target_x) - DIFF_W'(req_data.eye_x);
         f1_dy_ff    <= DIFF_W'(req_data.target_y) - DIFF_W'(req_data.eye_y);
         f1_dz_ff    <= DIFF_W'(req_data.target_z) - DIFF_W'(req_data.eye_z);
         f2_ff       <= f2_in;
         f3_ff       <= f2_ff;
         f3_max_ff   <= f3_max_in;
         f4_ff       <= f3_ff;
         f4_chunk_ff <= f4_chunk_in;
         f4_byte_ff  <= f4_byte_in;
         f5_ff       <= f4_ff;
         f5_left_ff  <= f5_left_in;
         f5_right_ff <= f5_right_in;
         f6_ff       <= f6_in;
      end
   end

endmodule

FILE: rtl/core/lay_queue.sv
// Short queue between the front end and the angle pipeline.
// Register storage with a read pointer mux; depends on lay_pkg.
module lay_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  lay_pkg::lay_vec_type   push_data,
   input  logic                   pop,
   output lay_pkg::lay_vec_type   head,
   output lay_pkg::lay_qstat_type stat
);
   import lay_pkg::*;

   lay_vec_type       entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QPTR_W:0]   count_ff, count_in;

   assign head           = entry_ff[rd_ptr_ff];
   assign stat.not_empty = (count_ff != '0);
   assign stat.full      = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));

   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_data;
   end

endmodule

FILE: rtl/core/lay_back.sv
// Back end: squares, pipelined integer square root, yaw and pitch CORDIC, rounding.
// One stage per square-root step and per CORDIC iteration; depends on lay_pkg.
module lay_back #(
   parameter int CORDIC_STEPS    = 16,
   parameter int ANGLE_FRAC_BITS = 7
) (
   input  logic                   clock,
   input  logic                   reset,
   input  lay_pkg::lay_vec_type   q_head,
   input  lay_pkg::lay_qstat_type q_stat,
   output logic                   q_pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output lay_pkg::lay_rsp_type   rsp_data
);
   import lay_pkg::*;

   localparam int SH  = ACC_FRAC - ANGLE_FRAC_BITS;
   localparam int R_W = Z_W + 1;
   localparam logic signed [R_W-1:0] HALF = R_W'(180 << ANGLE_FRAC_BITS);
   localparam logic signed [R_W-1:0] FULL = R_W'(360 << ANGLE_FRAC_BITS);
   localparam logic signed [R_W-1:0] PLIM = R_W'(90 << ANGLE_FRAC_BITS);
   localparam logic signed [R_W-1:0] RND  = R_W'(1 << (SH - 1));
   localparam logic signed [Z_W-1:0] Z180 = Z_W'(180 << ACC_FRAC);

   logic en;

   logic        b0_valid_ff;
   lay_vec_type b0_ff;

   logic                     b1_valid_ff;
   logic signed [SQ_W-1:0]   b1_sx_ff, b1_sz_ff;
   logic signed [CX_W-1:0]   b1_x_ff, b1_y_ff, b1_x_in, b1_y_in;
   logic signed [Z_W-1:0]    b1_z_ff, b1_z_in;
   logic                     b1_zero_ff;
   logic signed [NORM_W-1:0] b1_ny_ff;
   logic                     b1_deg_ff;

   // Square-root chain, with the yaw CORDIC riding along its first stages.
   logic                     c_valid_ff [ROOT_STEPS+1];
   logic [SQ_W-1:0]          c_rem_ff   [ROOT_STEPS+1];
   logic [SQ_W-1:0]          c_root_ff  [ROOT_STEPS+1];
   logic signed [CX_W-1:0]   c_x_ff     [ROOT_STEPS+1];
   logic signed [CX_W-1:0]   c_y_ff     [ROOT_STEPS+1];
   logic signed [Z_W-1:0]    c_z_ff     [ROOT_STEPS+1];
   logic                     c_zero_ff  [ROOT_STEPS+1];
   logic signed [NORM_W-1:0] c_ny_ff    [ROOT_STEPS+1];
   logic                     c_deg_ff   [ROOT_STEPS+1];

   logic                     p_valid_ff [CORDIC_STEPS+1];
   logic signed [CX_W-1:0]   p_x_ff     [CORDIC_STEPS+1];
   logic signed [CX_W-1:0]   p_y_ff     [CORDIC_STEPS+1];
   logic signed [Z_W-1:0]    p_z_ff     [CORDIC_STEPS+1];
   logic                     p_zero_ff  [CORDIC_STEPS+1];
   logic signed [Z_W-1:0]    p_yz_ff    [CORDIC_STEPS+1];
   logic                     p_yzero_ff [CORDIC_STEPS+1];
   logic                     p_deg_ff   [CORDIC_STEPS+1];

   // The horizontal length can reach sqrt(2) times 2^30, so it needs 31 bits.
   logic [NORM_W-1:0] h;
   logic              rsp_valid_ff;
   lay_rsp_type       rsp_data_ff, rsp_data_in;

   assign en        = !(rsp_valid_ff && rsp_stall);
   assign q_pop     = en && q_stat.not_empty;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Yaw is atan2(dx, dz); a vector with negative dz is first turned half a turn.
   always_comb begin
      b1_x_in = CX_W'(b0_ff.nz);
      b1_y_in = CX_W'(b0_ff.nx);
      b1_z_in = '0;
      if (b0_ff.nz < 0) begin
         b1_x_in = -b1_x_in;
         b1_y_in = -b1_y_in;
         b1_z_in = (b0_ff.nx >= 0) ? Z180 : -Z180;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b0_valid_ff   <= 1'b0;
         b1_valid_ff   <= 1'b0;
         c_valid_ff[0] <= 1'b0;
      end else if (en) begin
         b0_valid_ff   <= q_stat.not_empty;
         b1_valid_ff   <= b0_valid_ff;
         c_valid_ff[0] <= b1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b0_ff        <= q_head;
         b1_sx_ff     <= b0_ff.nx * b0_ff.nx;
         b1_sz_ff     <= b0_ff.nz * b0_ff.nz;
         b1_x_ff      <= b1_x_in;
         b1_y_ff      <= b1_y_in;
         b1_z_ff      <= b1_z_in;
         b1_zero_ff   <= (b0_ff.nx == '0) && (b0_ff.nz == '0);
         b1_ny_ff     <= b0_ff.ny;
         b1_deg_ff    <= b0_ff.degenerate;
         c_rem_ff[0]  <= SQ_W'(b1_sx_ff) + SQ_W'(b1_sz_ff);
         c_root_ff[0] <= '0;
         c_x_ff[0]    <= b1_x_ff;
         c_y_ff[0]    <= b1_y_ff;
         c_z_ff[0]    <= b1_z_ff;
         c_zero_ff[0] <= b1_zero_ff;
         c_ny_ff[0]   <= b1_ny_ff;
         c_deg_ff[0]  <= b1_deg_ff;
      end
   end

   for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
      localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (ROOT_STEPS - 1 - k));
      logic [SQ_W-1:0]        trial, rem_in, root_in;
      logic signed [CX_W-1:0] x_in, y_in;
      logic signed [Z_W-1:0]  z_in;

      always_comb begin
         trial = c_root_ff[k] + BIT;
         if (c_rem_ff[k] >= trial) begin
            rem_in  = c_rem_ff[k] - trial;
            root_in = (c_root_ff[k] >> 1) + BIT;
         end else begin
            rem_in  = c_rem_ff[k];
            root_in = c_root_ff[k] >> 1;
         end
      end

      if (k < CORDIC_STEPS) begin : g_yaw
         always_comb begin
            if (c_y_ff[k] >= 0) begin
               x_in = c_x_ff[k] + (c_y_ff[k] >>> k);
               y_in = c_y_ff[k] - (c_x_ff[k] >>> k);
               z_in = c_z_ff[k] + atan_deg(5'(k));
            end else begin
               x_in = c_x_ff[k] - (c_y_ff[k] >>> k);
               y_in = c_y_ff[k] + (c_x_ff[k] >>> k);
               z_in = c_z_ff[k] - atan_deg(5'(k));
            end
         end
      end else begin : g_hold
         always_comb begin
            x_in = c_x_ff[k];
            y_in = c_y_ff[k];
            z_in = c_z_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            c_valid_ff[k+1] <= 1'b0;
         end else if (en) begin
            c_valid_ff[k+1] <= c_valid_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            c_rem_ff[k+1]  <= rem_in;
            c_root_ff[k+1] <= root_in;
            c_x_ff[k+1]    <= x_in;
            c_y_ff[k+1]    <= y_in;
            c_z_ff[k+1]    <= z_in;
            c_zero_ff[k+1] <= c_zero_ff[k];
            c_ny_ff[k+1]   <= c_ny_ff[k];
            c_deg_ff[k+1]  <= c_deg_ff[k];
         end
      end
   end

   // Pitch is atan2(dy, h) with h never negative, so no half-turn is needed.
   assign h = c_root_ff[ROOT_STEPS][NORM_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff[0] <= 1'b0;
      end else if (en) begin
         p_valid_ff[0] <= c_valid_ff[ROOT_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_x_ff[0]     <= CX_W'({1'b0, h});
         p_y_ff[0]     <= CX_W'(c_ny_ff[ROOT_STEPS]);
         p_z_ff[0]     <= '0;
         p_zero_ff[0]  <= (c_ny_ff[ROOT_STEPS] == '0) && (h == '0);
         p_yz_ff[0]    <= c_z_ff[ROOT_STEPS];
         p_yzero_ff[0] <= c_zero_ff[ROOT_STEPS];
         p_deg_ff[0]   <= c_deg_ff[ROOT_STEPS];
      end
   end

   for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_pitch
      logic signed [CX_W-1:0] x_in, y_in;
      logic signed [Z_W-1:0]  z_in;

      always_comb begin
         if (p_y_ff[k] >= 0) begin
            x_in = p_x_ff[k] + (p_y_ff[k] >>> k);
            y_in = p_y_ff[k] - (p_x_ff[k] >>> k);
            z_in = p_z_ff[k] + atan_deg(5'(k));
         end else begin
            x_in = p_x_ff[k] - (p_y_ff[k] >>> k);
            y_in = p_y_ff[k] + (p_x_ff[k] >>> k);
            z_in = p_z_ff[k] - atan_deg(5'(k));
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            p_valid_ff[k+1] <= 1'b0;
         end else if (en) begin
            p_valid_ff[k+1] <= p_valid_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            p_x_ff[k+1]     <= x_in;
            p_y_ff[k+1]     <= y_in;
            p_z_ff[k+1]     <= z_in;
            p_zero_ff[k+1]  <= p_zero_ff[k];
            p_yz_ff[k+1]    <= p_yz_ff[k];
            p_yzero_ff[k+1] <= p_yzero_ff[k];
            p_deg_ff[k+1]   <= p_deg_ff[k];
         end
      end
   end

   // Round half up to output units; yaw gets a half turn and one wrap, pitch a clamp.
   always_comb begin
      logic signed [R_W-1:0] yz, pz, yaw, pitch;
      yz    = p_yzero_ff[CORDIC_STEPS] ? '0 : R_W'(p_yz_ff[CORDIC_STEPS]);
      pz    = p_zero_ff[CORDIC_STEPS]  ? '0 : R_W'(p_z_ff[CORDIC_STEPS]);
      yaw   = ((yz + RND) >>> SH) + HALF;
      pitch = (pz + RND) >>> SH;
      if (yaw > HALF) begin
         yaw = yaw - FULL;
      end else if (yaw <= -HALF) begin
         yaw = yaw + FULL;
      end
      if (pitch > PLIM)  pitch = PLIM;
      if (pitch < -PLIM) pitch = -PLIM;
      if (p_deg_ff[CORDIC_STEPS]) begin
         rsp_data_in.pitch_angle = '0;
         rsp_data_in.yaw_angle   = '0;
         rsp_data_in.degenerate  = 1'b1;
      end else begin
         rsp_data_in.pitch_angle = pitch[PITCH_W-1:0];
         rsp_data_in.yaw_angle   = yaw[YAW_W-1:0];
         rsp_data_in.degenerate  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= p_valid_ff[CORDIC_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) rsp_data_ff <= rsp_data_in;
   end

endmodule

FILE: tb/look_at_yaw_pitch_core_tb.sv
// Testbench for look_at_yaw_pitch_core: drives eye/target transactions and checks the angles.
// Depends on lay_pkg and the core; a scoreboard class holds the predicted responses.
`timescale 1ns / 100ps

class angle_scoreboard;
   lay_pkg::lay_rsp_type pending_angles[$];
   int mismatches;

   function automatic longint fshr(longint v, int s);
      if (v >= 0) return v >>> s;
      return -(((-(v + 1)) >>> s) + 1);
   endfunction

   function automatic longint vec_atan2(longint y, longint x);
      longint z, xs, ys;
      longint tab[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
                          14668, 7334, 3667, 1833, 917, 458, 229, 115,
                          57, 29, 14, 7, 4, 2, 1, 0};
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         z = (y >= 0) ? (180 <<< 16) : -(180 <<< 16);
         x = -x;
         y = -y;
      end
      for (int i = 0; i < 16; i++) begin
         xs = fshr(x, i);
         ys = fshr(y, i);
         if (y >= 0) begin
            x = x + ys; y = y - xs; z += tab[i];
         end else begin
            x = x - ys; y = y + xs; z -= tab[i];
         end
      end
      return z;
   endfunction

   function automatic longint units(longint z);
      return fshr(z + (1 <<< 8), 9);
   endfunction

   function automatic longint int_sqrt(longint unsigned n);
      longint unsigned rem, root, b;
      rem = n; root = 0; b = 64'd1 << 62;
      while (b > rem) b >>= 2;
      while (b != 0) begin
         if (rem >= root + b) begin
            rem -= root + b;
            root = (root >> 1) + b;
         end else begin
            root >>= 1;
         end
         b >>= 2;
      end
      return longint'(root);
   endfunction

   function void note_request(lay_pkg::lay_req_type r);
      longint d[3], mag[3], m, yaw, pitch, h;
      int lsh, rsh;
      lay_pkg::lay_rsp_type e;
      d[0] = longint'(r.target_x) - longint'(r.eye_x);
      d[1] = longint'(r.target_y) - longint'(r.eye_y);
      d[2] = longint'(r.target_z) - longint'(r.eye_z);
      if (d[0] == 0 && d[1] == 0 && d[2] == 0) begin
         e = '0;
         e.degenerate = 1'b1;
         pending_angles.push_back(e);
         return;
      end
      // Common shift so the largest magnitude lands in [2^29, 2^30).
      m = 0;
      for (int k = 0; k < 3; k++) begin
         mag[k] = (d[k] < 0) ? -d[k] : d[k];
         if (mag[k] > m) m = mag[k];
      end
      lsh = 0; rsh = 0;
      while (m < (64'sd1 <<< 29)) begin m <<= 1; lsh++; end
      while (m >= (64'sd1 <<< 30)) begin m >>= 1; rsh++; end
      for (int k = 0; k < 3; k++) begin
         mag[k] = (mag[k] << lsh) >> rsh;
         d[k] = (d[k] < 0) ? -mag[k] : mag[k];
      end
      yaw = units(vec_atan2(d[0], d[2])) + (180 <<< 7);
      while (yaw > (180 <<< 7)) yaw -= (360 <<< 7);
      while (yaw <= -(180 <<< 7)) yaw += (360 <<< 7);
      h = int_sqrt(longint'(d[0] * d[0]) + longint'(d[2] * d[2]));
      pitch = units(vec_atan2(d[1], h));
      if (pitch > (90 <<< 7)) pitch = 90 <<< 7;
      if (pitch < -(90 <<< 7)) pitch = -(90 <<< 7);
      e.pitch_angle = pitch[14:0];
      e.yaw_angle = yaw[15:0];
      e.degenerate = 1'b0;
      pending_angles.push_back(e);
   endfunction

   function void check_response(lay_pkg::lay_rsp_type a);
      lay_pkg::lay_rsp_type e;
      if (pending_angles.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected response %p", a);
         return;
      end
      e = pending_angles.pop_front();
      if (a.pitch_angle !== e.pitch_angle || a.yaw_angle !== e.yaw_angle ||
          a.degenerate !== e.degenerate) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch: expected pitch %0d yaw %0d deg %0b, got pitch %0d yaw %0d deg %0b",
                     e.pitch_angle, e.yaw_angle, e.degenerate,
                     a.pitch_angle, a.yaw_angle, a.degenerate);
      end
   endfunction
endclass

module look_at_yaw_pitch_core_tb;
   import lay_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   lay_req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   lay_rsp_type rsp_data;

   angle_scoreboard sb = new();
   int idle_cycles = 0;
   bit long_hold = 1'b0;
   bit hold_done = 1'b0;
   bit stim_done = 1'b0;

   localparam int WATCHDOG = 20000;

   look_at_yaw_pitch_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int gap_len();
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
      if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
      return 0;
   endfunction

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return $urandom_range(0, 7) - 4;
         3: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
         default: return $urandom;
      endcase
   endfunction

   // Valid stays high after acceptance so that transactions can follow back to back;
   // whoever idles the channel drops it.
   task automatic send_request(lay_req_type r);
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      sb.note_request(r);
   endtask

   task automatic send_with_gap(lay_req_type r);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      send_request(r);
   endtask

   function automatic lay_req_type make_req(logic [31:0] ex, ey, ez, tx, ty, tz);
      lay_req_type r;
      r.eye_x = ex; r.eye_y = ey; r.eye_z = ez;
      r.target_x = tx; r.target_y = ty; r.target_z = tz;
      return r;
   endfunction

   // Response side: random stalls plus one long hold-off while requests keep coming.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) sb.check_response(rsp_data);
         if (long_hold) rsp_stall <= 1'b1;
         else rsp_stall <= ($urandom_range(0, 3) == 0) ||
                           ($urandom_range(0, 99) == 0);
      end
   end

   initial begin
      repeat (200) @(posedge clock);
      long_hold = 1'b1;
      repeat (150) @(posedge clock);
      long_hold = 1'b0;
      hold_done = 1'b1;
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      lay_req_type r;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // Directed: coincident points, straight up/down, axes and extreme coordinates.
      send_request(make_req(0, 0, 0, 0, 0, 0));
      send_request(make_req(32'h8000_0000, 32'h7fff_ffff, 5, 32'h8000_0000, 32'h7fff_ffff, 5));
      send_request(make_req(0, 0, 0, 0, 32'h0001_0000, 0));
      send_request(make_req(0, 0, 0, 0, 32'hffff_0000, 0));
      send_request(make_req(0, 0, 0, 1, 0, 0));
      send_request(make_req(0, 0, 0, -1, 0, 0));
      send_request(make_req(0, 0, 0, 0, 0, 1));
      send_request(make_req(0, 0, 0, 0, 0, -1));
      send_request(make_req(0, 0, 0, -1, 0, -1));
      send_request(make_req(0, 0, 0, 1, 1, -1));
      send_request(make_req(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                            32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
      send_request(make_req(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                            32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
      send_request(make_req(32'h8000_0000, 0, 0, 32'h7fff_ffff, 0, 0));
      send_request(make_req(0, 0, 32'h7fff_ffff, 0, 0, 32'h8000_0000));
      send_request(make_req(0, 32'h7fff_ffff, 0, 1, 32'h8000_0000, 0));
      send_request(make_req(0, 0, 0, 32'hffff_ffff, 0, 32'h0000_0001));
      // Random part; a pause part-way waits for the pipeline to drain completely.
      for (int n = 0; n < 1550; n++) begin
         if (n == 700) begin
            req_valid <= 1'b0;
            while (sb.pending_angles.size() != 0) @(posedge clock);
            repeat (80) @(posedge clock);
         end
         r = make_req(rand_coord(), rand_coord(), rand_coord(),
                      rand_coord(), rand_coord(), rand_coord());
         if ($urandom_range(0, 15) == 0) r = make_req(r.eye_x, r.eye_y, r.eye_z,
                                                      r.eye_x, r.eye_y, r.eye_z);
         else if ($urandom_range(0, 15) == 0) begin
            r.target_x = r.eye_x;
            r.target_z = r.eye_z;
         end
         if (long_hold) send_request(r);
         else send_with_gap(r);
      end
      req_valid <= 1'b0;
      while (!hold_done || sb.pending_angles.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending_angles.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
